// File: rtl/aart_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle rigid transform.
// No dependencies; every module of the block imports this package.
package aart_pkg;

    // Fixed-point formats and iteration counts.
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 17;
    localparam int ANG_IN_W = 16;
    localparam int ANG_LSH  = 17;                  // Q3.13 to Q2.30
    localparam int ANG_W    = 35;                  // reduced angle, Q2.30 with headroom
    localparam int CW       = 34;                  // CORDIC x and y
    localparam int ROOT_W   = 32;
    localparam int SUM_W    = 64;
    localparam int REM_W    = ROOT_W + 3;
    localparam int QB       = FRAC_BITS + 1;       // quotient bits of a normalised component
    localparam int NUM_W    = DATA_W + FRAC_BITS;
    localparam int CS_W     = FRAC_BITS + 3;       // cosine and sine in QF
    localparam int T_W      = CS_W + 1;            // one minus cosine
    localparam int TX_W     = 35;                  // first-level products after rounding
    localparam int PROD_W   = 64;
    localparam int CS_SH    = 30 - FRAC_BITS;

    localparam int SQRT_STAGES = ROOT_W;
    localparam int PIPE_DEPTH  = 2 + SQRT_STAGES + 1 + QB + 1 + 5;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word ONE_Q = t_word'(longint'(1) << FRAC_BITS);

    // Angle constants in Q2.30.
    localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = ANG_W'(64'sd6746518852);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);
    localparam logic signed [CW-1:0]    GAIN_Q30    = CW'(64'sd652032874);
    localparam logic signed [CW-1:0]    CS_RND      = CW'(64'sd1 << (29 - FRAC_BITS));
    localparam logic signed [PROD_W-1:0] RND_HALF   = PROD_W'(64'sd1 << (FRAC_BITS - 1));

    // Arctangent of two to the minus i, Q2.30.
    localparam logic [29:0] ATAN_TAB [0:29] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2
    };

    // Configuration register indexes.
    localparam logic CFG_UNIT_TOL = 1'b0;
    localparam logic CFG_MIN_LEN  = 1'b1;

    // Matrix rows.
    localparam logic [1:0] ROW_0    = 2'd0;
    localparam logic [1:0] ROW_1    = 2'd1;
    localparam logic [1:0] ROW_2    = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd3;

    // Axis and translation of one transaction.
    typedef struct packed {
        t_word ax;
        t_word ay;
        t_word az;
        t_word sx;
        t_word sy;
        t_word sz;
    } t_geo;

    // CORDIC working state.
    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] a;
        logic                    flip;
    } t_cord;

    // Side information carried through the divider.
    typedef struct packed {
        logic [ROOT_W-1:0]     len;
        logic                  norm;
        logic                  err;
        logic [2:0]            neg;
        t_geo                  geo;
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_side;

    // Finished matrix handed to the row serialiser.
    typedef struct packed {
        logic                 err;
        t_word [2:0][2:0]     rot;
        t_word [2:0]          tr;
    } t_mat;

    // Round half up and drop the fraction, in 64-bit two's complement.
    function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sum;
        sum = p + RND_HALF;
        return sum >>> FRAC_BITS;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic t_word sat32(input logic signed [PROD_W-1:0] v);
        t_word res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/aart_rowser.sv
// Row serialiser: holds one finished matrix and hands it out one row per transaction.
// Depends on aart_pkg for the matrix type and row codes.
module aart_rowser import aart_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mat       i_item,
    input  logic       i_item_valid,
    output logic       o_item_take,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_row_index,
    output t_word      o_col0,
    output t_word      o_col1,
    output t_word      o_col2,
    output t_word      o_col3,
    output logic       o_axis_error,
    output logic       o_last_row
);

    logic        r_busy;
    logic [1:0]  r_row;
    t_mat        r_item;
    logic        w_last;
    logic        w_done;
    t_word [3:0] w_col;

    // The held matrix is free once its final row leaves.
    assign w_last      = r_item.err || (r_row == ROW_LAST);
    assign w_done      = r_busy && !i_out_stall;
    assign o_item_take = i_item_valid && (!r_busy || (w_done && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_0;
        end else if (o_item_take) begin
            r_busy <= 1'b1;
            r_row  <= ROW_0;
        end else if (w_done) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_item <= i_item;
        end
    end

    // Select the columns of the current row; an error result is all zero.
    always_comb begin
        unique case (r_row)
            ROW_0:   w_col = {r_item.tr[0], r_item.rot[0][2], r_item.rot[0][1], r_item.rot[0][0]};
            ROW_1:   w_col = {r_item.tr[1], r_item.rot[1][2], r_item.rot[1][1], r_item.rot[1][0]};
            ROW_2:   w_col = {r_item.tr[2], r_item.rot[2][2], r_item.rot[2][1], r_item.rot[2][0]};
            default: w_col = {ONE_Q, t_word'(0), t_word'(0), t_word'(0)};
        endcase
        if (r_item.err) begin
            w_col = '0;
        end
    end

    assign o_out_valid  = r_busy;
    assign o_row_index  = r_row;
    assign o_col0       = w_col[0];
    assign o_col1       = w_col[1];
    assign o_col2       = w_col[2];
    assign o_col3       = w_col[3];
    assign o_axis_error = r_item.err;
    assign o_last_row   = w_last;

endmodule

// File: rtl/axis_angle_rigid_transform.sv
// Top level of the axis-angle rigid transform: pipeline, configuration and row output.
// Depends on aart_pkg and instantiates aart_rowser.

// Takes one transaction of axis, angle (Q3.13 radians) and translation (Q16.16) and
// returns the 4x4 rigid-body matrix as four row transactions, rows 0 to 3, with
// last_row on row 3. An axis that needs normalising but is too short gives a single
// all-zero row with axis_error and last_row set. The datapath is a 58-stage pipeline
// (squares, a 32-stage square root with the 16-step CORDIC alongside it, a 17-stage
// divider for the three normalised components, then two levels of multiply and round)
// and can take a transaction every cycle unless its last stage waits on the row output;
// the row output port moves one row a cycle while i_out_stall is low, and gives four
// rows per transaction, one for a short axis. The configuration port is always ready.
module axis_angle_rigid_transform import aart_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [DATA_W-1:0]   i_axis_x,
    input  logic signed [DATA_W-1:0]   i_axis_y,
    input  logic signed [DATA_W-1:0]   i_axis_z,
    input  logic signed [ANG_IN_W-1:0] i_turn_angle,
    input  logic signed [DATA_W-1:0]   i_shift_x,
    input  logic signed [DATA_W-1:0]   i_shift_y,
    input  logic signed [DATA_W-1:0]   i_shift_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_row_index,
    output logic signed [DATA_W-1:0]   o_col0,
    output logic signed [DATA_W-1:0]   o_col1,
    output logic signed [DATA_W-1:0]   o_col2,
    output logic signed [DATA_W-1:0]   o_col3,
    output logic                       o_axis_error,
    output logic                       o_last_row
);

    localparam int SQ_OUT = SQRT_STAGES;

    logic                  w_adv;
    logic                  w_take;
    logic                  w_accept;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [CFG_W-1:0]      r_unit_tol;
    logic [CFG_W-1:0]      r_min_len;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_tol <= CFG_W'(1);
            r_min_len  <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UNIT_TOL: r_unit_tol <= i_cfg_data;
                CFG_MIN_LEN:  r_min_len  <= i_cfg_data;
                default:      r_min_len  <= r_min_len;
            endcase
        end
    end

    // The whole pipeline moves together unless its last stage waits on the serialiser.
    assign w_adv      = !r_vld[PIPE_DEPTH-1] || w_take;
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    // Stage 1: squares of the axis and the first angle wrap.
    logic signed [SUM_W-1:0] w_sqx, w_sqy, w_sqz;
    logic signed [ANG_W-1:0] w_ang, w_ang_wrap;
    logic [SUM_W-1:0]        r_p1_sq [3];
    logic signed [ANG_W-1:0] r_p1_ang;
    t_geo                    r_p1_geo;

    always_comb begin
        w_sqx = i_axis_x * i_axis_x;
        w_sqy = i_axis_y * i_axis_y;
        w_sqz = i_axis_z * i_axis_z;
        w_ang = {{(ANG_W - ANG_IN_W - ANG_LSH){i_turn_angle[ANG_IN_W-1]}},
                 i_turn_angle, {ANG_LSH{1'b0}}};
        if (w_ang > PI_Q30) begin
            w_ang_wrap = w_ang - TWO_PI_Q30;
        end else if (w_ang < -PI_Q30) begin
            w_ang_wrap = w_ang + TWO_PI_Q30;
        end else begin
            w_ang_wrap = w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_sq[0] <= w_sqx;
            r_p1_sq[1] <= w_sqy;
            r_p1_sq[2] <= w_sqz;
            r_p1_ang   <= w_ang_wrap;
            r_p1_geo   <= '{ax: i_axis_x, ay: i_axis_y, az: i_axis_z,
                            sx: i_shift_x, sy: i_shift_y, sz: i_shift_z};
        end
    end

    // Square-root and CORDIC section; element 0 is loaded by stage 2.
    logic [REM_W-1:0]  r_sr_rem  [0:SQRT_STAGES];
    logic [ROOT_W-1:0] r_sr_root [0:SQRT_STAGES];
    logic [SUM_W-1:0]  r_sr_rad  [0:SQRT_STAGES];
    t_geo              r_sr_geo  [0:SQRT_STAGES];
    t_cord             r_sr_cord [0:SQRT_STAGES];

    // Stage 2: sum of squares and fold of the angle into plus or minus pi/2.
    t_cord w_fold;

    always_comb begin
        w_fold.x    = GAIN_Q30;
        w_fold.y    = '0;
        w_fold.flip = 1'b0;
        w_fold.a    = r_p1_ang;
        if (r_p1_ang > HALF_PI_Q30) begin
            w_fold.a    = r_p1_ang - PI_Q30;
            w_fold.flip = 1'b1;
        end else if (r_p1_ang < -HALF_PI_Q30) begin
            w_fold.a    = r_p1_ang + PI_Q30;
            w_fold.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_rad[0]  <= r_p1_sq[0] + r_p1_sq[1] + r_p1_sq[2];
            r_sr_geo[0]  <= r_p1_geo;
            r_sr_cord[0] <= w_fold;
        end
    end

    // One root bit per stage, and one CORDIC rotation in each of the first CORDIC_STEPS stages.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_trial;
        t_cord            w_cord;

        assign w_cur   = {r_sr_rem[k][REM_W-3:0], r_sr_rad[k][SUM_W-1 -: 2]};
        assign w_trial = REM_W'({r_sr_root[k], 2'b01});

        if (k < CORDIC_STEPS) begin : g_rot
            always_comb begin
                w_cord.flip = r_sr_cord[k].flip;
                if (!r_sr_cord[k].a[ANG_W-1]) begin
                    w_cord.x = r_sr_cord[k].x - (r_sr_cord[k].y >>> k);
                    w_cord.y = r_sr_cord[k].y + (r_sr_cord[k].x >>> k);
                    w_cord.a = r_sr_cord[k].a - ANG_W'(ATAN_TAB[k]);
                end else begin
                    w_cord.x = r_sr_cord[k].x + (r_sr_cord[k].y >>> k);
                    w_cord.y = r_sr_cord[k].y - (r_sr_cord[k].x >>> k);
                    w_cord.a = r_sr_cord[k].a + ANG_W'(ATAN_TAB[k]);
                end
            end
        end else begin : g_hold
            assign w_cord = r_sr_cord[k];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_cur >= w_trial) begin
                    r_sr_rem[k+1]  <= w_cur - w_trial;
                    r_sr_root[k+1] <= {r_sr_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    r_sr_rem[k+1]  <= w_cur;
                    r_sr_root[k+1] <= {r_sr_root[k][ROOT_W-2:0], 1'b0};
                end
                r_sr_rad[k+1]  <= r_sr_rad[k] << 2;
                r_sr_geo[k+1]  <= r_sr_geo[k];
                r_sr_cord[k+1] <= w_cord;
            end
        end
    end

    // Decision stage: normalise or not, short-axis check, sine and cosine to QF,
    // and the dividends of the three components.
    logic [NUM_W-1:0]         r_dv_num  [0:QB][3];
    t_side                    r_dv_side [0:QB];
    logic [ROOT_W-1:0]        r_dv_rem  [1:QB][3];
    logic [QB-1:0]            r_dv_q    [1:QB][3];

    logic signed [ROOT_W+1:0] w_dev;
    logic [ROOT_W+1:0]        w_dev_abs;
    logic                     w_norm;
    logic                     w_short;
    logic signed [CW-1:0]     w_cx, w_sy;
    logic signed [CS_W-1:0]   w_c, w_s;
    t_word                    w_v   [3];
    logic [DATA_W-1:0]        w_mag [3];
    t_side                    w_side;

    always_comb begin
        w_dev     = $signed({2'b00, r_sr_root[SQ_OUT]}) - (ROOT_W+2)'(ONE_Q);
        w_dev_abs = w_dev[ROOT_W+1] ? -w_dev : w_dev;
        w_norm    = w_dev_abs > (ROOT_W+2)'(r_unit_tol);
        // Sum of squares at or below min squared, from root and remainder.
        w_short   = (r_sr_root[SQ_OUT] < ROOT_W'(r_min_len)) ||
                    ((r_sr_root[SQ_OUT] == ROOT_W'(r_min_len)) && (r_sr_rem[SQ_OUT] == '0));
        w_cx = (r_sr_cord[SQ_OUT].x + CS_RND) >>> CS_SH;
        w_sy = (r_sr_cord[SQ_OUT].y + CS_RND) >>> CS_SH;
        w_c  = r_sr_cord[SQ_OUT].flip ? -CS_W'(w_cx) : CS_W'(w_cx);
        w_s  = r_sr_cord[SQ_OUT].flip ? -CS_W'(w_sy) : CS_W'(w_sy);
        w_v[0] = r_sr_geo[SQ_OUT].ax;
        w_v[1] = r_sr_geo[SQ_OUT].ay;
        w_v[2] = r_sr_geo[SQ_OUT].az;
        for (int n = 0; n < 3; n++) begin
            w_mag[n] = w_v[n][DATA_W-1] ? DATA_W'(-w_v[n]) : DATA_W'(w_v[n]);
        end
        w_side.len  = r_sr_root[SQ_OUT];
        w_side.norm = w_norm;
        w_side.err  = w_norm && w_short;
        w_side.neg  = {w_v[2][DATA_W-1], w_v[1][DATA_W-1], w_v[0][DATA_W-1]};
        w_side.geo  = r_sr_geo[SQ_OUT];
        w_side.c    = w_c;
        w_side.s    = w_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_side[0] <= w_side;
            for (int n = 0; n < 3; n++) begin
                r_dv_num[0][n] <= {w_mag[n], {FRAC_BITS{1'b0}}} +
                                  NUM_W'(r_sr_root[SQ_OUT] >> 1);
            end
        end
    end

    // Restoring divider, one quotient bit per stage for each component.
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [ROOT_W-1:0] w_rin [3];
        logic [QB-1:0]     w_qin [3];
        logic [ROOT_W:0]   w_cur [3];
        logic [ROOT_W:0]   w_dif [3];

        always_comb begin
            for (int n = 0; n < 3; n++) begin
                if (j == 0) begin
                    w_rin[n] = ROOT_W'(r_dv_num[j][n][NUM_W-1:QB]);
                    w_qin[n] = '0;
                end else begin
                    w_rin[n] = r_dv_rem[(j == 0) ? 1 : j][n];
                    w_qin[n] = r_dv_q[(j == 0) ? 1 : j][n];
                end
                w_cur[n] = {w_rin[n], r_dv_num[j][n][B]};
                w_dif[n] = w_cur[n] - {1'b0, r_dv_side[j].len};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_side[j+1] <= r_dv_side[j];
                for (int n = 0; n < 3; n++) begin
                    r_dv_num[j+1][n] <= r_dv_num[j][n];
                    if (w_cur[n] >= {1'b0, r_dv_side[j].len}) begin
                        r_dv_rem[j+1][n] <= w_dif[n][ROOT_W-1:0];
                        r_dv_q[j+1][n]   <= {w_qin[n][QB-2:0], 1'b1};
                    end else begin
                        r_dv_rem[j+1][n] <= w_cur[n][ROOT_W-1:0];
                        r_dv_q[j+1][n]   <= {w_qin[n][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Vector select and one minus cosine.
    t_word                  w_raw [3];
    t_word                  r_v_vec [3];
    logic signed [T_W-1:0]  r_v_t;
    logic signed [CS_W-1:0] r_v_c, r_v_s;
    logic                   r_v_err;
    t_word [2:0]            r_v_tr;

    assign w_raw[0] = r_dv_side[QB].geo.ax;
    assign w_raw[1] = r_dv_side[QB].geo.ay;
    assign w_raw[2] = r_dv_side[QB].geo.az;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 3; n++) begin
                if (!r_dv_side[QB].norm) begin
                    r_v_vec[n] <= w_raw[n];
                end else if (r_dv_side[QB].neg[n]) begin
                    r_v_vec[n] <= -t_word'(r_dv_q[QB][n]);
                end else begin
                    r_v_vec[n] <= t_word'(r_dv_q[QB][n]);
                end
            end
            r_v_t   <= T_W'(ONE_Q) - T_W'(r_dv_side[QB].c);
            r_v_c   <= r_dv_side[QB].c;
            r_v_s   <= r_dv_side[QB].s;
            r_v_err <= r_dv_side[QB].err;
            r_v_tr  <= {r_dv_side[QB].geo.sz, r_dv_side[QB].geo.sy, r_dv_side[QB].geo.sx};
        end
    end

    // First multiply: t and s times each component.
    logic signed [PROD_W-1:0] r_m1_pt [3];
    logic signed [PROD_W-1:0] r_m1_ps [3];
    t_word                    r_m1_vec [3];
    logic signed [CS_W-1:0]   r_m1_c;
    logic                     r_m1_err;
    t_word [2:0]              r_m1_tr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 3; n++) begin
                r_m1_pt[n]  <= r_v_t * r_v_vec[n];
                r_m1_ps[n]  <= r_v_s * r_v_vec[n];
                r_m1_vec[n] <= r_v_vec[n];
            end
            r_m1_c   <= r_v_c;
            r_m1_err <= r_v_err;
            r_m1_tr  <= r_v_tr;
        end
    end

    // Round the first products.
    logic signed [TX_W-1:0] r_m2_tv [3];
    logic signed [TX_W-1:0] r_m2_sv [3];
    t_word                  r_m2_vec [3];
    logic signed [CS_W-1:0] r_m2_c;
    logic                   r_m2_err;
    t_word [2:0]            r_m2_tr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 3; n++) begin
                r_m2_tv[n]  <= TX_W'(rnd_q(r_m1_pt[n]));
                r_m2_sv[n]  <= TX_W'(rnd_q(r_m1_ps[n]));
                r_m2_vec[n] <= r_m1_vec[n];
            end
            r_m2_c   <= r_m1_c;
            r_m2_err <= r_m1_err;
            r_m2_tr  <= r_m1_tr;
        end
    end

    // Second multiply; products keep their low 64 bits. Order: xx xy xz yy yz zz.
    logic signed [PROD_W-1:0] r_m3_p [6];
    logic signed [TX_W-1:0]   r_m3_sv [3];
    logic signed [CS_W-1:0]   r_m3_c;
    logic                     r_m3_err;
    t_word [2:0]              r_m3_tr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_p[0] <= r_m2_tv[0] * r_m2_vec[0];
            r_m3_p[1] <= r_m2_tv[0] * r_m2_vec[1];
            r_m3_p[2] <= r_m2_tv[0] * r_m2_vec[2];
            r_m3_p[3] <= r_m2_tv[1] * r_m2_vec[1];
            r_m3_p[4] <= r_m2_tv[1] * r_m2_vec[2];
            r_m3_p[5] <= r_m2_tv[2] * r_m2_vec[2];
            r_m3_sv   <= r_m2_sv;
            r_m3_c    <= r_m2_c;
            r_m3_err  <= r_m2_err;
            r_m3_tr   <= r_m2_tr;
        end
    end

    // Round the second products.
    logic signed [PROD_W-1:0] r_m4_a [6];
    logic signed [TX_W-1:0]   r_m4_sv [3];
    logic signed [CS_W-1:0]   r_m4_c;
    logic                     r_m4_err;
    t_word [2:0]              r_m4_tr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 6; n++) begin
                r_m4_a[n] <= rnd_q(r_m3_p[n]);
            end
            r_m4_sv  <= r_m3_sv;
            r_m4_c   <= r_m3_c;
            r_m4_err <= r_m3_err;
            r_m4_tr  <= r_m3_tr;
        end
    end

    // Assemble and saturate the rotation elements.
    logic signed [PROD_W-1:0] w_sx, w_sy2, w_sz, w_c64;
    t_mat                     w_mat;
    t_mat                     r_m5_mat;

    always_comb begin
        w_sx  = PROD_W'(r_m4_sv[0]);
        w_sy2 = PROD_W'(r_m4_sv[1]);
        w_sz  = PROD_W'(r_m4_sv[2]);
        w_c64 = PROD_W'(r_m4_c);
        w_mat.err       = r_m4_err;
        w_mat.tr        = r_m4_tr;
        w_mat.rot[0][0] = sat32(r_m4_a[0] + w_c64);
        w_mat.rot[0][1] = sat32(r_m4_a[1] - w_sz);
        w_mat.rot[0][2] = sat32(r_m4_a[2] + w_sy2);
        w_mat.rot[1][0] = sat32(r_m4_a[1] + w_sz);
        w_mat.rot[1][1] = sat32(r_m4_a[3] + w_c64);
        w_mat.rot[1][2] = sat32(r_m4_a[4] - w_sx);
        w_mat.rot[2][0] = sat32(r_m4_a[2] - w_sy2);
        w_mat.rot[2][1] = sat32(r_m4_a[4] + w_sx);
        w_mat.rot[2][2] = sat32(r_m4_a[5] + w_c64);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m5_mat <= w_mat;
        end
    end

    // Row output.
    aart_rowser u_rowser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (r_m5_mat),
        .i_item_valid (r_vld[PIPE_DEPTH-1]),
        .o_item_take  (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_axis_error (o_axis_error),
        .o_last_row   (o_last_row)
    );

`ifndef SYNTHESIS
    // Rows of one transaction leave in ascending order.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_row |=>
        o_out_valid && (o_row_index == $past(o_row_index) + 2'd1))
        else $error("row sequence broken");

    // An error result is a single row 0 that closes the transaction.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_axis_error |-> o_last_row && (o_row_index == ROW_0))
        else $error("error result not a single row");

    // The pipeline only holds while the serialiser is busy.
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] && !w_adv |-> o_out_valid)
        else $error("pipeline held with idle output");
`endif

endmodule

// File: dv/axis_angle_rigid_transform_tb.sv
// Self-checking testbench for the axis-angle rigid transform: directed table, then random phases.
// Depends on aart_pkg and the axis_angle_rigid_transform RTL; the predictor takes widths, shifts,
// step counts, the arctangent table, the row codes and ONE_Q from the package.
`timescale 1ns / 100ps

module axis_angle_rigid_transform_tb;
    import aart_pkg::*;

    localparam int  LIMIT_CYCLES = 300000;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint Q_ONE     = 64'sd65536;
    localparam longint PI_FX     = 64'sd3373259426;
    localparam longint TWO_PI_FX = 64'sd6746518852;
    localparam longint HPI_FX    = 64'sd1686629713;
    localparam longint K_FX      = 64'sd652032874;

    // One input transaction and one row transaction.
    typedef struct {
        t_word ax, ay, az;
        logic signed [ANG_IN_W-1:0] ang;
        t_word sx, sy, sz;
        bit short_axis;
    } pose_t;

    typedef struct {
        logic [1:0] row;
        t_word      c0, c1, c2, c3;
        logic       err;
        logic       last;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_word i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic signed [ANG_IN_W-1:0] i_turn_angle = '0;
    t_word i_shift_x = '0, i_shift_y = '0, i_shift_z = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = CFG_UNIT_TOL;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [1:0] o_row_index;
    t_word o_col0, o_col1, o_col2, o_col3;
    logic o_axis_error, o_last_row;

    row_t  rows_due[$];
    pose_t directed[$];
    longint tol_reg, min_reg;
    int    mismatches = 0;
    int    cycles = 0;
    int    burst_left = 4;

    axis_angle_rigid_transform dut (.*);

    always #5 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: switches between a few stall patterns of random length.
    int stall_mode = 0, stall_left = 0, stall_tick = 0;
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(5, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_tick[1];
        endcase
    end

    function automatic t_word clamp_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_word'(v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd32768) >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(longint v, longint unsigned len);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = ((mag << FRAC_BITS) + (len >> 1)) / len;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Computes the expected rows of one transform and queues them.
    task automatic predict_matrix(input pose_t p);
        longint x, y, z, a, cx, cy, nx, c, s, t, tx, ty, tz, dev;
        longint m[3][3];
        longint unsigned sumsq, len;
        t_word tr[3];
        bit flip;
        row_t r;
        x = p.ax; y = p.ay; z = p.az;
        tr[0] = p.sx; tr[1] = p.sy; tr[2] = p.sz;
        sumsq = longint'(x * x) + longint'(y * y) + longint'(z * z);
        len = root_floor(sumsq);
        dev = longint'(len) - Q_ONE;
        if (dev < 0) dev = -dev;
        if (dev > tol_reg) begin
            if (sumsq <= longint'(min_reg * min_reg)) begin
                rows_due.push_back('{ROW_0, 0, 0, 0, 0, 1'b1, 1'b1});
                return;
            end
            x = unit_component(x, len);
            y = unit_component(y, len);
            z = unit_component(z, len);
        end
        // Angle reduction, quadrant fold and CORDIC rotation.
        a = longint'(p.ang) * 64'sd131072;
        flip = 1'b0;
        if (a > PI_FX) a -= TWO_PI_FX;
        if (a < -PI_FX) a += TWO_PI_FX;
        if (a > HPI_FX) begin
            a -= PI_FX;
            flip = 1'b1;
        end else if (a < -HPI_FX) begin
            a += PI_FX;
            flip = 1'b1;
        end
        cx = K_FX;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
            if (a >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                a -= longint'(ATAN_TAB[i]);
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                a += longint'(ATAN_TAB[i]);
            end
            cx = nx;
        end
        cx = (cx + (64'sd1 << (CS_SH - 1))) >>> CS_SH;
        cy = (cy + (64'sd1 << (CS_SH - 1))) >>> CS_SH;
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        // Rodrigues rotation terms.
        t = Q_ONE - c;
        tx = qmul(t, x);
        ty = qmul(t, y);
        tz = qmul(t, z);
        m[0][0] = qmul(tx, x) + c;
        m[0][1] = qmul(tx, y) - qmul(s, z);
        m[0][2] = qmul(tx, z) + qmul(s, y);
        m[1][0] = qmul(tx, y) + qmul(s, z);
        m[1][1] = qmul(ty, y) + c;
        m[1][2] = qmul(ty, z) - qmul(s, x);
        m[2][0] = qmul(tx, z) - qmul(s, y);
        m[2][1] = qmul(ty, z) + qmul(s, x);
        m[2][2] = qmul(tz, z) + c;
        for (int k = 0; k < 3; k++) begin
            r.row  = 2'(k);
            r.c0   = clamp_word(m[k][0]);
            r.c1   = clamp_word(m[k][1]);
            r.c2   = clamp_word(m[k][2]);
            r.c3   = tr[k];
            r.err  = 1'b0;
            r.last = 1'b0;
            rows_due.push_back(r);
        end
        rows_due.push_back('{ROW_LAST, 0, 0, 0, ONE_Q, 1'b0, 1'b1});
    endtask

    // Row checker.
    always @(posedge i_clk) begin
        row_t got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_row_index, o_col0, o_col1, o_col2, o_col3, o_axis_error, o_last_row};
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected row transaction: row %0d", got.row);
            end else begin
                want = rows_due.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Row mismatch: exp row %0d %h %h %h %h err %b last %b,",
                                  " got row %0d %h %h %h %h err %b last %b"},
                                 want.row, want.c0, want.c1, want.c2, want.c3,
                                 want.err, want.last,
                                 got.row, got.c0, got.c1, got.c2, got.c3,
                                 got.err, got.last);
                end
            end
        end
    end

    // Sends one transaction, then closes the burst with a random gap when it runs out.
    task automatic send_pose(input pose_t p);
        i_in_valid   <= 1'b1;
        i_axis_x     <= p.ax;
        i_axis_y     <= p.ay;
        i_axis_z     <= p.az;
        i_turn_angle <= p.ang;
        i_shift_x    <= p.sx;
        i_shift_y    <= p.sy;
        i_shift_z    <= p.sz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (p.short_axis)
            rows_due.push_back('{ROW_0, 0, 0, 0, 0, 1'b1, 1'b1});
        else
            predict_matrix(p);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    // Lets the pipeline empty, then writes one configuration register.
    task automatic write_reg(input logic idx, input longint value);
        i_in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_UNIT_TOL) tol_reg = value;
        else min_reg = value;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        int kind;
        kind = $urandom_range(0, 9);
        p.ang = $urandom;
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        p.short_axis = 1'b0;
        case (kind)
            0: begin
                p.ax = $urandom_range(0, 4) - 2;
                p.ay = $urandom_range(0, 4) - 2;
                p.az = $urandom_range(0, 4) - 2;
            end
            1, 2, 3, 4: begin
                p.ax = $urandom_range(0, 131072) - 65536;
                p.ay = $urandom_range(0, 131072) - 65536;
                p.az = $urandom_range(0, 131072) - 65536;
            end
            5, 6: begin
                p.ax = $urandom;
                p.ay = $urandom;
                p.az = $urandom;
            end
            7: begin
                p.ax = $urandom_range(0, 2097152) - 1048576;
                p.ay = $urandom_range(0, 2097152) - 1048576;
                p.az = $urandom_range(0, 2097152) - 1048576;
            end
            default: begin
                // Close to a unit axis along one coordinate.
                p.ax = $urandom_range(0, 64) - 32;
                p.ay = $urandom_range(0, 64) - 32;
                p.az = $urandom_range(0, 64) - 32;
                case ($urandom_range(0, 2))
                    0: p.ax += ($urandom_range(0, 1) != 0) ? 65536 : -65536;
                    1: p.ay += ($urandom_range(0, 1) != 0) ? 65536 : -65536;
                    default: p.az += ($urandom_range(0, 1) != 0) ? 65536 : -65536;
                endcase
            end
        endcase
        return p;
    endfunction

    initial begin
        tol_reg = 1;
        min_reg = 1;

        // Directed table: short axes carry a typed error row, the rest go to the predictor.
        directed.push_back('{0, 0, 0, 16'sd0, 0, 0, 0, 1'b1});
        directed.push_back('{1, 0, 0, 16'sd100, 5, 6, 7, 1'b1});
        directed.push_back('{0, 0, -1, 16'sd0, 0, 0, 0, 1'b1});
        directed.push_back('{65536, 0, 0, 16'sd0, 0, 0, 0, 1'b0});
        directed.push_back('{0, 65536, 0, 16'sh7fff, 1, 2, 3, 1'b0});
        directed.push_back('{0, 0, 65536, 16'sh8000, -1, -2, -3, 1'b0});
        directed.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd25736,
                             32'sh7fffffff, 32'sh80000000, 0, 1'b0});
        directed.push_back('{-65536, 0, 0, -16'sd12868, 0, 0, 0, 1'b0});
        directed.push_back('{2, 0, 0, 16'sd8192, 0, 0, 0, 1'b0});
        directed.push_back('{196608, 262144, 0, 16'sd16384, 65536, 0, 0, 1'b0});
        directed.push_back('{65537, 0, 0, 16'sd12868, 0, 0, 0, 1'b0});
        directed.push_back('{0, 65535, 0, 16'sd12869, 0, 0, 0, 1'b0});
        directed.push_back('{37837, 37837, 37837, -16'sd25736, 0, 0, 0, 1'b0});
        directed.push_back('{37837, -37837, 37837, -16'sd12869, 0, 0, 0, 1'b0});
        directed.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd4096,
                             32'sh80000000, 32'sh7fffffff, 32'shffffffff, 1'b0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_pose(directed[i]);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_UNIT_TOL, 65536);
                    write_reg(CFG_MIN_LEN, 0);
                end
                1: begin
                    write_reg(CFG_UNIT_TOL, 0);
                    write_reg(CFG_MIN_LEN, 65536);
                end
                2: begin
                    write_reg(CFG_UNIT_TOL, $urandom_range(0, 65536));
                    write_reg(CFG_MIN_LEN, $urandom_range(0, 65536));
                end
                default: begin
                    write_reg(CFG_UNIT_TOL, 1);
                    write_reg(CFG_MIN_LEN, 1);
                end
            endcase
            for (int n = 0; n < 80; n++) begin
                if (ph == 1 && n == 40) begin
                    // Hold off until the pipeline has handed back everything.
                    i_in_valid <= 1'b0;
                    while (rows_due.size() != 0) @(posedge i_clk);
                end
                send_pose(random_pose());
            end
        end

        i_in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && rows_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/aart_pkg.sv
rtl/aart_rowser.sv
rtl/axis_angle_rigid_transform.sv
dv/axis_angle_rigid_transform_tb.sv
